// ----- hdl/bged_pkg.sv -----
// Shared types and codes for the button gesture and encoder detent block.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package bged_pkg;

   // Fixed field widths of the transfer payloads.
   localparam int unsigned TIME_WIDTH      = 32;
   localparam int unsigned ENC_COUNT_WIDTH = 16;
   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 16;
   localparam int unsigned DETENT_WIDTH    = 5;

   // Operation codes of an input item.
   localparam logic [1:0] OP_PRESS   = 2'd0;
   localparam logic [1:0] OP_RELEASE = 2'd1;
   localparam logic [1:0] OP_POLL    = 2'd2;

   // Button event codes of a result item.
   localparam logic [1:0] EV_NONE   = 2'd0;
   localparam logic [1:0] EV_CLICK  = 2'd1;
   localparam logic [1:0] EV_DOUBLE = 2'd2;
   localparam logic [1:0] EV_LONG   = 2'd3;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_EDGE_GUARD   = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MIN_TAP      = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LONG_PRESS   = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DOUBLE_CLICK = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DETENT       = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INVERT       = 3'd5;

   // Register reset values.
   localparam logic [15:0] EDGE_GUARD_RESET   = 16'd10;
   localparam logic [15:0] MIN_TAP_RESET      = 16'd30;
   localparam logic [15:0] LONG_PRESS_RESET   = 16'd600;
   localparam logic [15:0] DOUBLE_CLICK_RESET = 16'd450;
   localparam logic [DETENT_WIDTH-1:0] DETENT_RESET = 5'd4;
   localparam logic        INVERT_RESET       = 1'b1;

   typedef struct packed {
      logic [1:0]                 operation;
      logic [TIME_WIDTH-1:0]      time_ms;
      logic                       pin_held;
      logic [ENC_COUNT_WIDTH-1:0] encoder_count;
   } req_type;

   typedef struct packed {
      logic signed [7:0] detents;
      logic [1:0]        button_event;
   } rsp_type;

   // Status of the serial divider as seen by the sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

// ----- hdl/bged_div.sv -----
// Bit-serial signed divider by a small divisor (1 to 16), one quotient bit per cycle.
// Depends on bged_pkg for the status struct.
`default_nettype none

module bged_div #(
   parameter int unsigned ACC_WIDTH = 18
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [ACC_WIDTH-1:0]      numer,
   input  wire logic [4:0]                denom,
   output bged_pkg::div_status_type       status,
   output logic      [ACC_WIDTH-1:0]      quot_mag,
   output logic      [3:0]                rem_mag,
   output logic                           negative
);

   localparam int unsigned CNT_WIDTH = $clog2(ACC_WIDTH + 1);

   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                 done_ff, done_in;
   logic [ACC_WIDTH-1:0] num_ff, num_in;
   logic [3:0]           rem_ff, rem_in;
   logic [4:0]           den_ff, den_in;
   logic                 neg_ff, neg_in;
   logic [4:0]           trial;
   logic                 fits;
   logic [4:0]           reduced;

   // Shift the next dividend bit into the partial remainder and try the subtract.
   assign trial   = {rem_ff, num_ff[ACC_WIDTH-1]};
   assign fits    = (trial >= den_ff);
   assign reduced = trial - den_ff;

   always_comb begin
      cnt_in  = cnt_ff;
      done_in = done_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      if (start) begin
         neg_in  = numer[ACC_WIDTH-1];
         num_in  = numer[ACC_WIDTH-1] ? (~numer + 1'b1) : numer;
         den_in  = denom;
         rem_in  = 4'd0;
         cnt_in  = CNT_WIDTH'(ACC_WIDTH);
         done_in = 1'b0;
      end else if (cnt_ff != '0) begin
         num_in = {num_ff[ACC_WIDTH-2:0], fits};
         rem_in = fits ? reduced[3:0] : trial[3:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_WIDTH'(1)) begin
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign status   = '{busy: (cnt_ff != '0), done: done_ff};
   assign quot_mag = num_ff;
   assign rem_mag  = rem_ff;
   assign negative = neg_ff;

endmodule

`default_nettype wire

// ----- hdl/button_gesture_and_encoder_detents_top.sv -----
// Top level of the button gesture and rotary encoder detent detector.
// Depends on bged_pkg and instantiates the serial divider bged_div.
`default_nettype none

// Usage:
// Input items arrive on the req_ channel: a press edge, a release edge or a poll
// tick, each with a millisecond timestamp. Edges produce no result. Every poll
// produces exactly one transfer on the rsp_ channel carrying the whole detents
// turned since the previous poll (saturated to plus or minus 127) and the button
// event classified at that poll (none, click, double click or long press).
// The block works on one item at a time and holds req_stall high while busy.
// A press edge updates the button state and returns to idle; a release edge runs
// the minimum tap check, then the long press check. A poll forms the encoder
// difference and starts the divider, then runs the button checks, waits for the
// divider and registers the result. The detent division runs bit-serially, one
// quotient bit per cycle over COUNTER_WIDTH + 2 bits, while the button timing
// checks step through one shared 32-bit subtract-and-compare unit in parallel.
// The first poll after reset only captures the counter.
// Results sit in an output register; the next item is taken while a result waits.
// If the receiver stalls and a second poll finishes, that poll holds until the
// earlier result transfer completes. The csr_ port is always ready and should be
// written only while the block is idle. Synchronous reset restores the register
// defaults and clears all gesture and encoder state; no clearing pass is needed.

module button_gesture_and_encoder_detents_top #(
   parameter int unsigned COUNTER_WIDTH = 16
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     req_valid,
   output logic                                          req_stall,
   input  wire bged_pkg::req_type                        req_data,
   output logic                                          rsp_valid,
   input  wire logic                                     rsp_stall,
   output bged_pkg::rsp_type                             rsp_data,
   input  wire logic                                     csr_valid,
   output logic                                          csr_ready,
   input  wire logic [bged_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  wire logic [bged_pkg::CSR_DATA_WIDTH-1:0]      csr_data
);

   // Accumulator holds remainder plus the wrapped delta, with sign and headroom.
   localparam int unsigned ACC_W = COUNTER_WIDTH + 2;
   localparam int unsigned EXT_W = (COUNTER_WIDTH > bged_pkg::ENC_COUNT_WIDTH) ?
                                   COUNTER_WIDTH : bged_pkg::ENC_COUNT_WIDTH;
   localparam int unsigned TW    = bged_pkg::TIME_WIDTH;

   // Sequencer states.
   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_PRESS     = 4'd1;
   localparam logic [3:0] ST_REL_MIN   = 4'd2;
   localparam logic [3:0] ST_REL_LONG  = 4'd3;
   localparam logic [3:0] ST_ENC_DIFF  = 4'd4;
   localparam logic [3:0] ST_ENC_ACC   = 4'd5;
   localparam logic [3:0] ST_DIV_START = 4'd6;
   localparam logic [3:0] ST_BTN_GUARD = 4'd7;
   localparam logic [3:0] ST_BTN_MIN   = 4'd8;
   localparam logic [3:0] ST_BTN_LDUR  = 4'd9;
   localparam logic [3:0] ST_BTN_HOLD  = 4'd10;
   localparam logic [3:0] ST_BTN_TAPS  = 4'd11;
   localparam logic [3:0] ST_BTN_CLICK = 4'd12;
   localparam logic [3:0] ST_WAIT_DIV  = 4'd13;
   localparam logic [3:0] ST_RESULT    = 4'd14;

   logic [3:0] state_ff, state_in;

   // Captured item fields.
   logic [TW-1:0]            ms_ff, ms_in;
   logic                     pin_ff, pin_in;
   logic [COUNTER_WIDTH-1:0] cnt_ff, cnt_in;

   // Configuration registers.
   logic [15:0] guard_ff, guard_in;
   logic [15:0] min_tap_ff, min_tap_in;
   logic [15:0] long_ff, long_in;
   logic [15:0] dbl_ff, dbl_in;
   logic [bged_pkg::DETENT_WIDTH-1:0] detent_ff, detent_in;
   logic        invert_ff, invert_in;

   // Encoder state.
   logic [COUNTER_WIDTH-1:0] prev_ff, prev_in;
   logic                     captured_ff, captured_in;
   logic signed [4:0]        rem_ff, rem_in;
   logic [COUNTER_WIDTH-1:0] diff_ff, diff_in;
   logic [ACC_W-1:0]         acc_ff, acc_in;
   logic                     div_on_ff, div_on_in;

   // Button state.
   logic          held_ff, held_in;
   logic [TW-1:0] press_start_ff, press_start_in;
   logic [TW-1:0] last_edge_ff, last_edge_in;
   logic [TW-1:0] first_tap_ff, first_tap_in;
   logic [7:0]    tap_ff, tap_in;
   logic          new_press_ff, new_press_in;
   logic          long_rep_ff, long_rep_in;
   logic          click_wait_ff, click_wait_in;
   logic          resync_ff, resync_in;
   logic          ge_min_ff, ge_min_in;
   logic [1:0]    ev_ff, ev_in;
   logic [7:0]    det_ff, det_in;

   // Output register.
   logic              rsp_valid_ff, rsp_valid_in;
   bged_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // Shared time compare unit: (a - b) mod 2^32 >= threshold.
   logic [TW-1:0] cmp_a, cmp_b, cmp_diff;
   logic [15:0]   cmp_thr;
   logic          cmp_ge;

   // Helpers.
   logic                       req_accept;
   logic [EXT_W-1:0]           enc_ext;
   logic [COUNTER_WIDTH-1:0]   enc_count;
   logic [ACC_W-1:0]           delta_ext;
   logic [ACC_W-1:0]           delta_dir;
   logic [4:0]                 denom;
   logic                       lr_now;
   logic [7:0]                 tap_sat;
   logic                       taps_double;
   logic                       taps_set_first;
   logic [6:0]                 det_mag;
   logic [7:0]                 det_signed;

   // Divider interface.
   logic                       div_start;
   bged_pkg::div_status_type   div_status;
   logic [ACC_W-1:0]           div_quot;
   logic [3:0]                 div_rem;
   logic                       div_neg;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // Low counter bits, zero-extended when the counter is wider than the field.
   assign enc_ext   = EXT_W'(req_data.encoder_count);
   assign enc_count = enc_ext[COUNTER_WIDTH-1:0];

   // Wrapped difference as a signed value, then optionally negated.
   assign delta_ext = {{2{diff_ff[COUNTER_WIDTH-1]}}, diff_ff};
   assign delta_dir = invert_ff ? (~delta_ext + 1'b1) : delta_ext;

   // A detent size of zero acts as one, anything above sixteen as sixteen.
   always_comb begin
      if (detent_ff == 5'd0) begin
         denom = 5'd1;
      end else if (detent_ff > 5'd16) begin
         denom = 5'd16;
      end else begin
         denom = detent_ff;
      end
   end

   always_comb begin
      case (state_ff)
         ST_REL_MIN: begin
            cmp_a = ms_ff;        cmp_b = press_start_ff; cmp_thr = min_tap_ff;
         end
         ST_REL_LONG, ST_BTN_HOLD: begin
            cmp_a = ms_ff;        cmp_b = press_start_ff; cmp_thr = long_ff;
         end
         ST_BTN_MIN: begin
            cmp_a = last_edge_ff; cmp_b = press_start_ff; cmp_thr = min_tap_ff;
         end
         ST_BTN_LDUR: begin
            cmp_a = last_edge_ff; cmp_b = press_start_ff; cmp_thr = long_ff;
         end
         ST_BTN_CLICK: begin
            cmp_a = ms_ff;        cmp_b = first_tap_ff;   cmp_thr = dbl_ff;
         end
         default: begin
            cmp_a = ms_ff;        cmp_b = last_edge_ff;   cmp_thr = guard_ff;
         end
      endcase
   end

   assign cmp_diff = cmp_a - cmp_b;
   assign cmp_ge   = (cmp_diff >= TW'(cmp_thr));

   assign tap_sat = (tap_ff == 8'd255) ? tap_ff : (tap_ff + 8'd1);

   // Pending taps pair up: each completed pair is a double click, an odd tap
   // leaves a click waiting with a fresh window.
   assign taps_double    = click_wait_ff ? (tap_ff >= 8'd1) : (tap_ff >= 8'd2);
   assign taps_set_first = click_wait_ff ? (tap_ff >= 8'd2) : (tap_ff >= 8'd1);

   // Saturated, signed detent count from the divider.
   assign det_mag    = (div_quot > ACC_W'(127)) ? 7'd127 : div_quot[6:0];
   assign det_signed = div_neg ? (~{1'b0, det_mag} + 1'b1) : {1'b0, det_mag};

   assign lr_now    = new_press_ff ? 1'b0 : long_rep_ff;
   assign div_start = (state_ff == ST_DIV_START);

   always_comb begin
      state_in       = state_ff;
      ms_in          = ms_ff;
      pin_in         = pin_ff;
      cnt_in         = cnt_ff;
      guard_in       = guard_ff;
      min_tap_in     = min_tap_ff;
      long_in        = long_ff;
      dbl_in         = dbl_ff;
      detent_in      = detent_ff;
      invert_in      = invert_ff;
      prev_in        = prev_ff;
      captured_in    = captured_ff;
      rem_in         = rem_ff;
      diff_in        = diff_ff;
      acc_in         = acc_ff;
      div_on_in      = div_on_ff;
      held_in        = held_ff;
      press_start_in = press_start_ff;
      last_edge_in   = last_edge_ff;
      first_tap_in   = first_tap_ff;
      tap_in         = tap_ff;
      new_press_in   = new_press_ff;
      long_rep_in    = long_rep_ff;
      click_wait_in  = click_wait_ff;
      resync_in      = resync_ff;
      ge_min_in      = ge_min_ff;
      ev_in          = ev_ff;
      det_in         = det_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid && csr_ready) begin
         case (csr_index)
            bged_pkg::CSR_EDGE_GUARD:   guard_in   = csr_data;
            bged_pkg::CSR_MIN_TAP:      min_tap_in = csr_data;
            bged_pkg::CSR_LONG_PRESS:   long_in    = csr_data;
            bged_pkg::CSR_DOUBLE_CLICK: dbl_in     = csr_data;
            bged_pkg::CSR_DETENT:       detent_in  = csr_data[bged_pkg::DETENT_WIDTH-1:0];
            bged_pkg::CSR_INVERT:       invert_in  = csr_data[0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               ms_in  = req_data.time_ms;
               pin_in = req_data.pin_held;
               cnt_in = enc_count;
               case (req_data.operation)
                  bged_pkg::OP_PRESS:   state_in = ST_PRESS;
                  bged_pkg::OP_RELEASE: state_in = ST_REL_MIN;
                  bged_pkg::OP_POLL:    state_in = ST_ENC_DIFF;
                  default:              state_in = ST_IDLE;
               endcase
            end
         end

         ST_PRESS: begin
            if (!held_ff && cmp_ge) begin
               held_in        = 1'b1;
               press_start_in = ms_ff;
               new_press_in   = 1'b1;
            end
            last_edge_in = ms_ff;
            state_in     = ST_IDLE;
         end

         ST_REL_MIN: begin
            ge_min_in = cmp_ge;
            state_in  = ST_REL_LONG;
         end

         ST_REL_LONG: begin
            if (held_ff && ge_min_ff) begin
               held_in = 1'b0;
               if (!cmp_ge) begin
                  tap_in = tap_sat;
               end
            end
            last_edge_in = ms_ff;
            state_in     = ST_IDLE;
         end

         ST_ENC_DIFF: begin
            ev_in = bged_pkg::EV_NONE;
            det_in = 8'd0;
            prev_in = cnt_ff;
            if (!captured_ff) begin
               captured_in = 1'b1;
               div_on_in   = 1'b0;
               state_in    = ST_BTN_GUARD;
            end else begin
               diff_in   = cnt_ff - prev_ff;
               div_on_in = 1'b1;
               state_in  = ST_ENC_ACC;
            end
         end

         ST_ENC_ACC: begin
            acc_in   = {{(ACC_W-5){rem_ff[4]}}, rem_ff} + delta_dir;
            state_in = ST_DIV_START;
         end

         ST_DIV_START: begin
            state_in = ST_BTN_GUARD;
         end

         ST_BTN_GUARD: begin
            resync_in = held_ff && !pin_ff && cmp_ge;
            state_in  = ST_BTN_MIN;
         end

         ST_BTN_MIN: begin
            ge_min_in = cmp_ge;
            state_in  = ST_BTN_LDUR;
         end

         ST_BTN_LDUR: begin
            // A stale held state with the pin up is closed at the last edge.
            if (resync_ff) begin
               held_in = 1'b0;
               if (ge_min_ff && !cmp_ge) begin
                  tap_in = tap_sat;
               end
            end
            state_in = ST_BTN_HOLD;
         end

         ST_BTN_HOLD: begin
            new_press_in = 1'b0;
            long_rep_in  = lr_now;
            if (held_ff && !lr_now && cmp_ge) begin
               long_rep_in   = 1'b1;
               ev_in         = bged_pkg::EV_LONG;
               click_wait_in = 1'b0;
            end
            state_in = ST_BTN_TAPS;
         end

         ST_BTN_TAPS: begin
            if (!long_rep_ff) begin
               click_wait_in = click_wait_ff ^ tap_ff[0];
               if (taps_double) begin
                  ev_in = bged_pkg::EV_DOUBLE;
               end
               if (taps_set_first) begin
                  first_tap_in = ms_ff;
               end
            end
            tap_in   = 8'd0;
            state_in = ST_BTN_CLICK;
         end

         ST_BTN_CLICK: begin
            if (click_wait_ff && cmp_ge) begin
               ev_in         = bged_pkg::EV_CLICK;
               click_wait_in = 1'b0;
            end
            state_in = ST_WAIT_DIV;
         end

         ST_WAIT_DIV: begin
            if (!div_on_ff) begin
               state_in = ST_RESULT;
            end else if (div_status.done && !div_status.busy) begin
               det_in   = det_signed;
               rem_in   = div_neg ? (~{1'b0, div_rem} + 1'b1) : {1'b0, div_rem};
               state_in = ST_RESULT;
            end
         end

         ST_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.detents         = det_ff;
               rsp_data_in.button_event    = ev_ff;
               state_in                    = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         guard_ff       <= bged_pkg::EDGE_GUARD_RESET;
         min_tap_ff     <= bged_pkg::MIN_TAP_RESET;
         long_ff        <= bged_pkg::LONG_PRESS_RESET;
         dbl_ff         <= bged_pkg::DOUBLE_CLICK_RESET;
         detent_ff      <= bged_pkg::DETENT_RESET;
         invert_ff      <= bged_pkg::INVERT_RESET;
         prev_ff        <= '0;
         captured_ff    <= 1'b0;
         rem_ff         <= '0;
         div_on_ff      <= 1'b0;
         held_ff        <= 1'b0;
         press_start_ff <= '0;
         last_edge_ff   <= '0;
         first_tap_ff   <= '0;
         tap_ff         <= '0;
         new_press_ff   <= 1'b0;
         long_rep_ff    <= 1'b0;
         click_wait_ff  <= 1'b0;
         resync_ff      <= 1'b0;
         ge_min_ff      <= 1'b0;
         ev_ff          <= bged_pkg::EV_NONE;
         det_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         guard_ff       <= guard_in;
         min_tap_ff     <= min_tap_in;
         long_ff        <= long_in;
         dbl_ff         <= dbl_in;
         detent_ff      <= detent_in;
         invert_ff      <= invert_in;
         prev_ff        <= prev_in;
         captured_ff    <= captured_in;
         rem_ff         <= rem_in;
         div_on_ff      <= div_on_in;
         held_ff        <= held_in;
         press_start_ff <= press_start_in;
         last_edge_ff   <= last_edge_in;
         first_tap_ff   <= first_tap_in;
         tap_ff         <= tap_in;
         new_press_ff   <= new_press_in;
         long_rep_ff    <= long_rep_in;
         click_wait_ff  <= click_wait_in;
         resync_ff      <= resync_in;
         ge_min_ff      <= ge_min_in;
         ev_ff          <= ev_in;
         det_ff         <= det_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      ms_ff       <= ms_in;
      pin_ff      <= pin_in;
      cnt_ff      <= cnt_in;
      diff_ff     <= diff_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   bged_div #(
      .ACC_WIDTH (ACC_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (acc_ff),
      .denom    (denom),
      .status   (div_status),
      .quot_mag (div_quot),
      .rem_mag  (div_rem),
      .negative (div_neg)
   );

endmodule

`default_nettype wire
